### rtl/smdc_pkg.sv
// ----------------------------------------------------------------------------
// smdc_pkg: shared types and constants of the sliding median block
// Port widths, reset values and the link records passed along the cell row.
// ----------------------------------------------------------------------------
package smdc_pkg;

  localparam int MAX_WINDOW_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int MEDIAN_W = 16;
  localparam int COST_W   = 21;
  localparam int WLEN_W   = 6;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(8);

  // Broadcast control into every cell.
  typedef struct packed {
    logic step;     // request accepted: shift the row
    logic clr;      // window length written: empty the row
    logic full;     // window holds its full length
  } cell_ctl_t;

  // Flags a cell hands to its neighbors.
  typedef struct packed {
    logic le;       // entry valid and not above the new sample
    logic valid;    // entry holds a window sample
    logic rm_seen;  // leaving entry sits at or left of this cell
  } cell_link_t;

  // Status a cell reports to the top level.
  typedef struct packed {
    logic keep;     // entry after removal stays at or below the new sample
    logic rm;       // this cell holds the leaving entry
  } cell_stat_t;

  // Left edge of the row: acts as a minus-infinity entry that is always valid.
  localparam cell_link_t EDGE_LINK = '{le: 1'b1, valid: 1'b1, rm_seen: 1'b0};

endpackage

### rtl/smdc_if.sv
// ----------------------------------------------------------------------------
// smdc_if: request channels of the sliding median block
// Sample channel in, median and cost channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface smdc_in_if import smdc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface smdc_out_if import smdc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MEDIAN_W-1:0] median;
  logic [COST_W-1:0]   cost;

  modport source (output valid, output median, output cost, input ready);
  modport sink   (input valid, input median, input cost, output ready);
endinterface

### rtl/sliding_median_deviation_cost.sv
// ----------------------------------------------------------------------------
// sliding_median_deviation_cost: sliding-window lower median and L1 cost
// Keeps the last window_len samples sorted in a row of cells and reports
// the lower median and the summed absolute deviation from it.
// ----------------------------------------------------------------------------
// Each accepted sample enters a row of MAX_WINDOW cells that keep the window
// in ascending order; every cell also carries the age of its sample, so the
// oldest one is found and dropped in the same cycle as the new one is put in
// place. Once window_len samples are held, every request gives one result:
// the lower median (sorted entry ceil(len/2)-1) and the sum of |x - median|
// over the window, computed from running sums of the lower and upper halves.
// The cell row updates at the edge that accepts the sample; the half sums
// update at the following edge, and the next sample is taken only after
// that, so that the result stage reads the sums and the median register of
// this sample before they move on. The result is loaded into the output
// register after the sums have updated, as soon as that register is free,
// and a new sample may be accepted while a result waits in that register.
// Writing cfg_wdata (window length, 0 acts as 1, values above MAX_WINDOW act
// as MAX_WINDOW) empties the window; the first window_len-1 samples after
// that give no result. Write it only while idle.
// There is no memory and no clearing pass after reset.
// ----------------------------------------------------------------------------
module sliding_median_deviation_cost import smdc_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  smdc_in_if.sink           in_ch,
  smdc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [WLEN_W-1:0] cfg_wdata
);

  localparam int DW = SAMPLE_BITS;
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1);

  // configuration and window fill
  logic [WLEN_W-1:0] win_len_r;
  logic [LW-1:0]     fill_r, fill_nxt, k_len;
  logic              full, grow, emit;
  logic [AW-1:0]     idx, lim;

  // handshake and stage control
  logic in_acc, in_rdy, out_free, out_load;
  logic stg2_r, res_pend_r, out_valid_r;

  // cell row
  cell_ctl_t     ctl;
  logic [DW-1:0] s;
  cell_link_t    lnk_w   [MAX_WINDOW];
  cell_stat_t    stat_w  [MAX_WINDOW];
  logic [DW-1:0] val_w   [MAX_WINDOW];
  logic [DW-1:0] rval_w  [MAX_WINDOW];
  logic [DW-1:0] nval_w  [MAX_WINDOW];
  logic [AW-1:0] age_w   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] valid_vec, rm_vec;

  // half-sum update operands
  logic [DW-1:0]     rm_val;
  logic [COST_W-1:0] s_ext, rm_ext, lv_ext, rv_ext;
  logic [COST_W-1:0] add_nxt, sub_nxt, add_r, sub_r, ds_r, dlo;
  logic [COST_W-1:0] lower_sum_r, upper_sum_r, lower_sum_nxt, upper_sum_nxt;
  logic [DW-1:0]     med_r;
  logic              emit_r;
  logic [MEDIAN_W-1:0] out_median_r;
  logic [COST_W-1:0]   out_cost_r, out_cost_nxt;

  // --------------------------------------------------------------------------
  // Window length and fill bookkeeping
  // --------------------------------------------------------------------------
  always_comb begin
    if (win_len_r == '0) begin
      k_len = LW'(1);
    end else if (int'(win_len_r) > MAX_WINDOW) begin
      k_len = LW'(MAX_WINDOW);
    end else begin
      k_len = LW'(win_len_r);
    end
  end

  assign full     = (fill_r == k_len);
  assign fill_nxt = full ? k_len : fill_r + LW'(1);
  // boundary slot of the lower half after this sample: ceil(n/2) - 1
  assign idx      = AW'((fill_nxt - LW'(1)) >> 1);
  assign lim      = AW'(k_len - LW'(1));
  // lower half gains one slot when the fill goes from even to odd
  assign grow     = !full && fill_nxt[0];
  assign emit     = (fill_nxt == k_len);

  // --------------------------------------------------------------------------
  // Handshake: hold off while the half sums are being updated, or while a
  // finished result cannot move into the output register.
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = res_pend_r && out_free;
  assign in_rdy   = !stg2_r && (!res_pend_r || out_free);
  assign in_acc   = in_ch.valid && in_rdy;

  assign s   = DW'(in_ch.sample);
  assign ctl = '{step: in_acc, clr: cfg_we, full: full};

  // --------------------------------------------------------------------------
  // Cell row: cell 0 holds the smallest sample. Each cell sees its left and
  // right neighbor; the removal flag ripples left to right.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_link_t    lf;
    logic [DW-1:0] lv, rv;
    logic [AW-1:0] la, ra;
    logic          rle;

    if (i == 0) begin : g_left_edge
      assign lf = EDGE_LINK;
      assign lv = '0;
      assign la = '0;
    end else begin : g_left
      assign lf = lnk_w[i-1];
      assign lv = val_w[i-1];
      assign la = age_w[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_right_edge
      assign rle = 1'b0;
      assign rv  = '0;
      assign ra  = '0;
    end else begin : g_right
      assign rle = lnk_w[i+1].le;
      assign rv  = val_w[i+1];
      assign ra  = age_w[i+1];
    end

    assign rval_w[i]    = rv;
    assign valid_vec[i] = lnk_w[i].valid;
    assign rm_vec[i]    = stat_w[i].rm;

    smdc_cell #(
      .DW (DW),
      .AW (AW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .s_i       (s),
      .lim_i     (lim),
      .lf_i      (lf),
      .lval_i    (lv),
      .lage_i    (la),
      .rle_i     (rle),
      .rval_i    (rv),
      .rage_i    (ra),
      .lnk_o     (lnk_w[i]),
      .stat_o    (stat_w[i]),
      .val_o     (val_w[i]),
      .age_o     (age_w[i]),
      .val_nxt_o (nval_w[i])
    );
  end

  // value of the leaving sample (zero while filling)
  always_comb begin
    rm_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rm_val = rm_val | (val_w[i] & {DW{stat_w[i].rm}});
    end
  end

  // --------------------------------------------------------------------------
  // Lower-half sum change, chosen at the boundary slot. With the new sample
  // landing in the lower half the sum gains the sample and, unless the half
  // grows, loses the leaving sample (if it was in the lower half) or the old
  // boundary entry. Otherwise the lower half gains the entry past the boundary
  // when the leaving sample came out of it, or the boundary entry when it grows.
  // --------------------------------------------------------------------------
  assign s_ext  = COST_W'(s);
  assign rm_ext = COST_W'(rm_val);
  assign lv_ext = COST_W'(val_w[idx]);
  assign rv_ext = COST_W'(rval_w[idx]);

  always_comb begin
    if (!stat_w[idx].keep) begin
      add_nxt = s_ext;
      if (grow) begin
        sub_nxt = '0;
      end else begin
        sub_nxt = lnk_w[idx].rm_seen ? rm_ext : lv_ext;
      end
    end else begin
      if (grow) begin
        add_nxt = lv_ext;
      end else begin
        add_nxt = lnk_w[idx].rm_seen ? rv_ext : '0;
      end
      sub_nxt = lnk_w[idx].rm_seen ? rm_ext : '0;
    end
  end

  assign dlo           = add_r - sub_r;
  assign lower_sum_nxt = lower_sum_r + dlo;
  assign upper_sum_nxt = upper_sum_r + ds_r - dlo;

  // cost = h*m - lower + upper - (k-h)*m, and 2h - k is 1 for odd k, else 0
  assign out_cost_nxt = upper_sum_r - lower_sum_r + (k_len[0] ? COST_W'(med_r) : '0);

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WLEN_RESET;
      fill_r      <= '0;
      lower_sum_r <= '0;
      upper_sum_r <= '0;
      stg2_r      <= 1'b0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_len_r   <= cfg_wdata;
        fill_r      <= '0;
        lower_sum_r <= '0;
        upper_sum_r <= '0;
      end else begin
        if (in_acc) begin
          fill_r <= fill_nxt;
        end
        if (stg2_r) begin
          lower_sum_r <= lower_sum_nxt;
          upper_sum_r <= upper_sum_nxt;
        end
      end

      stg2_r <= in_acc;

      if (stg2_r) begin
        res_pend_r <= emit_r;
      end else if (out_load) begin
        res_pend_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      add_r  <= add_nxt;
      sub_r  <= sub_nxt;
      ds_r   <= s_ext - rm_ext;
      med_r  <= nval_w[idx];
      emit_r <= emit;
    end
    if (out_load) begin
      out_median_r <= MEDIAN_W'(med_r);
      out_cost_r   <= out_cost_nxt;
    end
  end

  assign in_ch.ready   = in_rdy;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = out_median_r;
  assign out_ch.cost   = out_cost_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(fill_r))
    else $error("valid cells disagree with fill count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + MAX_WINDOW'(1))) == '0)
    else $error("valid cells do not form a prefix of the row");

  a_one_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |-> $onehot(rm_vec))
    else $error("full window must drop exactly one sample");

  a_stage_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(stg2_r && res_pend_r))
    else $error("sum update overlaps a pending result");

endmodule

### rtl/smdc_cell.sv
// ----------------------------------------------------------------------------
// smdc_cell: one slot of the sorted window
// Holds one sample and its age; each request drops the oldest entry (if the
// window is full) and takes its new value from s_i, itself or a neighbor.
// ----------------------------------------------------------------------------
module smdc_cell import smdc_pkg::*; #(
  parameter int DW = SAMPLE_BITS_DEF,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_ctl_t     ctl_i,
  input  logic [DW-1:0] s_i,
  input  logic [AW-1:0] lim_i,
  input  cell_link_t    lf_i,
  input  logic [DW-1:0] lval_i,
  input  logic [AW-1:0] lage_i,
  input  logic          rle_i,
  input  logic [DW-1:0] rval_i,
  input  logic [AW-1:0] rage_i,
  output cell_link_t    lnk_o,
  output cell_stat_t    stat_o,
  output logic [DW-1:0] val_o,
  output logic [AW-1:0] age_o,
  output logic [DW-1:0] val_nxt_o
);

  logic [DW-1:0] val_r, val_nxt;
  logic [AW-1:0] age_r, age_nxt;
  logic          valid_r, valid_nxt;
  logic          rm, le, own_in, keep, take_s;

  assign rm     = ctl_i.full && valid_r && (age_r == lim_i);
  assign le     = valid_r && (val_r <= s_i);
  // own_in: after removal this slot still sees its own entry
  assign own_in = !(lf_i.rm_seen || rm);
  assign keep   = own_in ? le : rle_i;
  assign take_s = !keep && (lf_i.rm_seen ? le : lf_i.le);

  always_comb begin
    if (keep) begin
      val_nxt = own_in ? val_r : rval_i;
      age_nxt = (own_in ? age_r : rage_i) + AW'(1);
    end else if (take_s) begin
      val_nxt = s_i;
      age_nxt = '0;
    end else begin
      val_nxt = lf_i.rm_seen ? val_r : lval_i;
      age_nxt = (lf_i.rm_seen ? age_r : lage_i) + AW'(1);
    end
  end

  // grow the valid prefix until the window is full
  assign valid_nxt = ctl_i.full ? valid_r : lf_i.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_i.clr) begin
      valid_r <= 1'b0;
    end else if (ctl_i.step) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.step) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign lnk_o     = '{le: le, valid: valid_r, rm_seen: lf_i.rm_seen || rm};
  assign stat_o    = '{keep: keep, rm: rm};
  assign val_o     = val_r;
  assign age_o     = age_r;
  assign val_nxt_o = val_nxt;

endmodule
